FILE: rtl/core/ecpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpa_pkg: shared types and constants of the prime field point adder
// Holds the register indexes, reset values, sequencer states and the
// command and status groups between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package ecpa_pkg;

  // Default field width in bits.
  localparam int unsigned FieldBitsDef = 16;

  // Configuration register indexes.
  localparam logic CfgIdxPrime = 1'b0;
  localparam logic CfgIdxCoeff = 1'b1;

  // Reset values of the configuration registers.
  localparam int unsigned PrimeReset = 13;
  localparam int unsigned CoeffReset = 1;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    OP_DIV,
    OP_MUL
  } ecpa_op_e;

  // Command to the shared unit.
  typedef struct packed {
    logic     start;
    ecpa_op_e op;
  } ecpa_cmd_t;

  // Status from the shared unit.
  typedef struct packed {
    logic busy;
    logic done;
  } ecpa_stat_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WT,
    ST_CLASS,
    ST_SQ_GO,
    ST_SQ_WT,
    ST_TAN1,
    ST_TAN2,
    ST_TAN3,
    ST_INV_INIT,
    ST_INV_TEST,
    ST_DIV_GO,
    ST_DIV_WT,
    ST_QM_GO,
    ST_QM_WT,
    ST_SL_GO,
    ST_SL_WT,
    ST_SS_GO,
    ST_SS_WT,
    ST_X3,
    ST_DY,
    ST_Y_GO,
    ST_Y_WT,
    ST_INF,
    ST_OUT
  } ecpa_state_e;

endpackage

FILE: rtl/core/ecpa_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpa_unit: shared bit-serial divide and modular multiply unit
// Divide gives quotient and remainder of a by b, one quotient bit per cycle.
// Multiply gives a*b mod p by double and add, one bit of b per cycle.
// ----------------------------------------------------------------------------
module ecpa_unit #(
  parameter int unsigned FIELD_BITS = ecpa_pkg::FieldBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ecpa_pkg::ecpa_cmd_t   cmd_i,
  input  logic [FIELD_BITS-1:0] opa_i,
  input  logic [FIELD_BITS-1:0] opb_i,
  input  logic [FIELD_BITS-1:0] prime_i,
  output ecpa_pkg::ecpa_stat_t  stat_o,
  output logic [FIELD_BITS-1:0] quo_o,
  output logic [FIELD_BITS-1:0] res_o
);

  localparam int unsigned W  = FIELD_BITS;
  localparam int unsigned CW = $clog2(W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  ecpa_pkg::ecpa_op_e  op_q, op_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [W-1:0]        acc_q, acc_d;
  logic [W-1:0]        sh_q, sh_d;
  logic [W-1:0]        opd_q, opd_d;
  logic [W-1:0]        quo_q, quo_d;

  // One step of either operation.
  logic [W:0] trial;
  logic [W:0] dbl;
  logic [W-1:0] dbl_r;
  logic [W:0] addx;
  logic [W-1:0] mul_r;

  always_comb begin
    trial = {acc_q, sh_q[W-1]};
    dbl   = {1'b0, acc_q} + {1'b0, acc_q};
    if (dbl >= {1'b0, prime_i}) begin
      dbl_r = W'(dbl - {1'b0, prime_i});
    end else begin
      dbl_r = dbl[W-1:0];
    end
    addx = {1'b0, dbl_r} + {1'b0, opd_q};
    if (addx >= {1'b0, prime_i}) begin
      mul_r = W'(addx - {1'b0, prime_i});
    end else begin
      mul_r = addx[W-1:0];
    end
  end

  // Step control.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    opd_d  = opd_q;
    quo_d  = quo_q;
    if (busy_q) begin
      sh_d = {sh_q[W-2:0], 1'b0};
      unique case (op_q)
        ecpa_pkg::OP_DIV: begin
          if (trial >= {1'b0, opd_q}) begin
            acc_d = W'(trial - {1'b0, opd_q});
            quo_d = {quo_q[W-2:0], 1'b1};
          end else begin
            acc_d = trial[W-1:0];
            quo_d = {quo_q[W-2:0], 1'b0};
          end
        end
        ecpa_pkg::OP_MUL: begin
          acc_d = sh_q[W-1] ? mul_r : dbl_r;
        end
        default: ;
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      cnt_d  = CW'(W - 1);
      acc_d  = '0;
      quo_d  = '0;
      sh_d   = (cmd_i.op == ecpa_pkg::OP_DIV) ? opa_i : opb_i;
      opd_d  = (cmd_i.op == ecpa_pkg::OP_DIV) ? opb_i : opa_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opd_q <= opd_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign res_o       = acc_q;

endmodule

FILE: rtl/core/ec_point_add_prime_field_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_point_add_prime_field_unit: affine point addition over GF(p)
// Adds two affine points on y^2 = x^3 + a*x + b with a configurable modulus.
// ----------------------------------------------------------------------------
// The input is not ready while a word is worked on. Every divide and
// multiply goes through one shared bit-serial unit: five reductions mod p,
// an optional square, then the extended Euclid loop (one divide and one
// multiply per iteration, about 1.44*FIELD_BITS iterations worst case),
// then three multiplies. The number of Euclid iterations sets how long a
// word takes. A result waits in the output register while the next word
// is already accepted. A modulus below two, a vertical line or a
// denominator without inverse gives the point at infinity with zero
// coordinates.
module ec_point_add_prime_field_unit #(
  parameter int unsigned FIELD_BITS = ecpa_pkg::FieldBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // first_x, first_y, second_x, second_y from the lowest bit up
  input  logic [((4*FIELD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sum_x, sum_y from the lowest bit up
  output logic [((2*FIELD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // at_infinity
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic                                   cfg_index_i,
  input  logic [FIELD_BITS-1:0]                  cfg_data_i
);

  localparam int unsigned W     = FIELD_BITS;
  localparam int unsigned OUT_W = ((2*FIELD_BITS+7)/8)*8;
  localparam int unsigned NOPS  = 5;

  // Modular add of residues.
  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[W-1:0];
  endfunction

  // Modular subtract of residues.
  function automatic logic [W-1:0] mod_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] p);
    logic [W-1:0] d;
    d = x - y;
    if (x < y) begin
      d = d + p;
    end
    return d;
  endfunction

  ecpa_pkg::ecpa_state_e st_q, st_d;
  logic [2:0]   k_q, k_d;
  logic [W-1:0] prime_q, prime_d;
  logic [W-1:0] coeff_q, coeff_d;
  logic [W-1:0] raw_q [NOPS];
  logic [W-1:0] raw_d [NOPS];
  logic [W-1:0] red_q [NOPS];
  logic [W-1:0] red_d [NOPS];
  logic [W-1:0] num_q, num_d, den_q, den_d;
  logic [W-1:0] r1_q, r1_d, r2_q, r2_d, c1_q, c1_d, c2_q, c2_d;
  logic [W-1:0] t_q, t_d, rt_q, rt_d, s_q, s_d, x3_q, x3_d;
  logic         rinf_q, rinf_d;
  logic [W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic         inf_q, inf_d;
  logic         ov_q, ov_d;

  ecpa_pkg::ecpa_cmd_t  cmd;
  ecpa_pkg::ecpa_stat_t stat;
  logic [W-1:0] opa, opb, quo, res;
  logic [W-1:0] x1, y1, x2, y2, a_r;

  assign x1  = red_q[0];
  assign y1  = red_q[1];
  assign x2  = red_q[2];
  assign y2  = red_q[3];
  assign a_r = red_q[4];

  ecpa_unit #(
    .FIELD_BITS(FIELD_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .prime_i(prime_q),
    .stat_o (stat),
    .quo_o  (quo),
    .res_o  (res)
  );

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    prime_d = prime_q;
    coeff_d = coeff_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ecpa_pkg::CfgIdxPrime: prime_d = cfg_data_i;
        ecpa_pkg::CfgIdxCoeff: coeff_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, unit commands and datapath updates.
  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    raw_d  = raw_q;
    red_d  = red_q;
    num_d  = num_q;
    den_d  = den_q;
    r1_d   = r1_q;
    r2_d   = r2_q;
    c1_d   = c1_q;
    c2_d   = c2_q;
    t_d    = t_q;
    rt_d   = rt_q;
    s_d    = s_q;
    x3_d   = x3_q;
    rinf_d = rinf_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    inf_d  = inf_q;
    ov_d   = ov_q;
    cmd.start = 1'b0;
    cmd.op    = ecpa_pkg::OP_MUL;
    opa = s_q;
    opb = t_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (st_q)
      ecpa_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          raw_d[0] = s_axis_tdata[W-1:0];
          raw_d[1] = s_axis_tdata[2*W-1:W];
          raw_d[2] = s_axis_tdata[3*W-1:2*W];
          raw_d[3] = s_axis_tdata[4*W-1:3*W];
          raw_d[4] = coeff_q;
          k_d      = '0;
          st_d     = (prime_q < W'(2)) ? ecpa_pkg::ST_INF : ecpa_pkg::ST_RED_GO;
        end
      end
      // Reduce the four coordinates and the coefficient mod p.
      ecpa_pkg::ST_RED_GO: begin
        cmd.start = 1'b1;
        cmd.op    = ecpa_pkg::OP_DIV;
        opa       = raw_q[k_q];
        opb       = prime_q;
        st_d      = ecpa_pkg::ST_RED_WT;
      end
      ecpa_pkg::ST_RED_WT: begin
        if (stat.done) begin
          red_d[k_q] = res;
          if (k_q == 3'(NOPS - 1)) begin
            st_d = ecpa_pkg::ST_CLASS;
          end else begin
            k_d  = k_q + 1'b1;
            st_d = ecpa_pkg::ST_RED_GO;
          end
        end
      end
      // Chord, tangent or vertical line.
      ecpa_pkg::ST_CLASS: begin
        if (x1 != x2) begin
          num_d = mod_sub(y2, y1, prime_q);
          den_d = mod_sub(x2, x1, prime_q);
          st_d  = ecpa_pkg::ST_INV_INIT;
        end else if (y1 == y2 && y1 != '0) begin
          st_d = ecpa_pkg::ST_SQ_GO;
        end else begin
          st_d = ecpa_pkg::ST_INF;
        end
      end
      ecpa_pkg::ST_SQ_GO: begin
        cmd.start = 1'b1;
        opa       = x1;
        opb       = x1;
        st_d      = ecpa_pkg::ST_SQ_WT;
      end
      ecpa_pkg::ST_SQ_WT: begin
        if (stat.done) begin
          t_d  = res;
          st_d = ecpa_pkg::ST_TAN1;
        end
      end
      // Tangent numerator 3*x^2 + a and denominator 2*y.
      ecpa_pkg::ST_TAN1: begin
        num_d = mod_add(t_q, t_q, prime_q);
        den_d = mod_add(y1, y1, prime_q);
        st_d  = ecpa_pkg::ST_TAN2;
      end
      ecpa_pkg::ST_TAN2: begin
        num_d = mod_add(num_q, t_q, prime_q);
        st_d  = ecpa_pkg::ST_TAN3;
      end
      ecpa_pkg::ST_TAN3: begin
        num_d = mod_add(num_q, a_r, prime_q);
        st_d  = ecpa_pkg::ST_INV_INIT;
      end
      // Extended Euclid for the inverse of the denominator.
      ecpa_pkg::ST_INV_INIT: begin
        r1_d = prime_q;
        r2_d = den_q;
        c1_d = '0;
        c2_d = W'(1);
        st_d = ecpa_pkg::ST_INV_TEST;
      end
      ecpa_pkg::ST_INV_TEST: begin
        if (r2_q != '0) begin
          st_d = ecpa_pkg::ST_DIV_GO;
        end else if (r1_q != W'(1)) begin
          st_d = ecpa_pkg::ST_INF;
        end else begin
          st_d = ecpa_pkg::ST_SL_GO;
        end
      end
      ecpa_pkg::ST_DIV_GO: begin
        cmd.start = 1'b1;
        cmd.op    = ecpa_pkg::OP_DIV;
        opa       = r1_q;
        opb       = r2_q;
        st_d      = ecpa_pkg::ST_DIV_WT;
      end
      ecpa_pkg::ST_DIV_WT: begin
        if (stat.done) begin
          // The quotient never exceeds p, so p itself is the only one to fold.
          t_d  = (quo == prime_q) ? '0 : quo;
          rt_d = res;
          st_d = ecpa_pkg::ST_QM_GO;
        end
      end
      ecpa_pkg::ST_QM_GO: begin
        cmd.start = 1'b1;
        opa       = t_q;
        opb       = c2_q;
        st_d      = ecpa_pkg::ST_QM_WT;
      end
      ecpa_pkg::ST_QM_WT: begin
        if (stat.done) begin
          c2_d = mod_sub(c1_q, res, prime_q);
          c1_d = c2_q;
          r1_d = r2_q;
          r2_d = rt_q;
          st_d = ecpa_pkg::ST_INV_TEST;
        end
      end
      // Slope and the coordinates of the sum.
      ecpa_pkg::ST_SL_GO: begin
        cmd.start = 1'b1;
        opa       = num_q;
        opb       = c1_q;
        st_d      = ecpa_pkg::ST_SL_WT;
      end
      ecpa_pkg::ST_SL_WT: begin
        if (stat.done) begin
          s_d  = res;
          st_d = ecpa_pkg::ST_SS_GO;
        end
      end
      ecpa_pkg::ST_SS_GO: begin
        cmd.start = 1'b1;
        opa       = s_q;
        opb       = s_q;
        st_d      = ecpa_pkg::ST_SS_WT;
      end
      ecpa_pkg::ST_SS_WT: begin
        if (stat.done) begin
          t_d  = mod_sub(res, x1, prime_q);
          st_d = ecpa_pkg::ST_X3;
        end
      end
      ecpa_pkg::ST_X3: begin
        x3_d = mod_sub(t_q, x2, prime_q);
        st_d = ecpa_pkg::ST_DY;
      end
      ecpa_pkg::ST_DY: begin
        t_d  = mod_sub(x1, x3_q, prime_q);
        st_d = ecpa_pkg::ST_Y_GO;
      end
      ecpa_pkg::ST_Y_GO: begin
        cmd.start = 1'b1;
        opa       = s_q;
        opb       = t_q;
        st_d      = ecpa_pkg::ST_Y_WT;
      end
      ecpa_pkg::ST_Y_WT: begin
        if (stat.done) begin
          t_d    = mod_sub(res, y1, prime_q);
          rinf_d = 1'b0;
          st_d   = ecpa_pkg::ST_OUT;
        end
      end
      ecpa_pkg::ST_INF: begin
        x3_d   = '0;
        t_d    = '0;
        rinf_d = 1'b1;
        st_d   = ecpa_pkg::ST_OUT;
      end
      // Hand the result to the output register once it is free.
      ecpa_pkg::ST_OUT: begin
        if (!ov_q || m_axis_tready) begin
          sx_d  = x3_q;
          sy_d  = t_q;
          inf_d = rinf_q;
          ov_d  = 1'b1;
          st_d  = ecpa_pkg::ST_IDLE;
        end
      end
      default: st_d = ecpa_pkg::ST_IDLE;
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ecpa_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      prime_q <= W'(ecpa_pkg::PrimeReset);
      coeff_q <= W'(ecpa_pkg::CoeffReset);
    end else begin
      st_q    <= st_d;
      ov_q    <= ov_d;
      prime_q <= prime_d;
      coeff_q <= coeff_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    raw_q  <= raw_d;
    red_q  <= red_d;
    num_q  <= num_d;
    den_q  <= den_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    c1_q   <= c1_d;
    c2_q   <= c2_d;
    t_q    <= t_d;
    rt_q   <= rt_d;
    s_q    <= s_d;
    x3_q   <= x3_d;
    rinf_q <= rinf_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    inf_q  <= inf_d;
  end

  assign s_axis_tready = (st_q == ecpa_pkg::ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_W'({sy_q, sx_q});
  assign m_axis_tuser  = inf_q;

endmodule

FILE: rtl/core/ecpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpa_checker: port-level checks of the point adder
// Watches the stream ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module ecpa_checker #(
  parameter int unsigned FIELD_BITS = ecpa_pkg::FieldBitsDef
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [((2*FIELD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // The point at infinity carries zero coordinates.
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("infinity with nonzero coordinates");

  // An accepted word closes the input.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input reopened right after a word");

  // A new result comes only at the end of a word's work.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind ec_point_add_prime_field_unit ecpa_checker #(
  .FIELD_BITS(FIELD_BITS)
) u_ecpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the prime field point adder
// Drives point pairs over the input stream under several field settings,
// predicts each sum with a behavioral model of affine point addition and
// checks every output word in order, with random idling and back pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FB = 16;
  localparam int unsigned CycleLimit = 10000000;

  typedef struct packed {
    logic [FB-1:0] sum_y;
    logic [FB-1:0] sum_x;
    logic          inf;
  } point_sum_t;

  // Scoreboard of expected sums, with its own copy of the field settings.
  class point_sum_board;
    bit [FB-1:0] prime = FB'(ecpa_pkg::PrimeReset);
    bit [FB-1:0] coeff = FB'(ecpa_pkg::CoeffReset);
    point_sum_t pending[$];
    int errors = 0;

    function longint unsigned madd(longint unsigned x, longint unsigned y,
                                   longint unsigned p);
      return (x + y) % p;
    endfunction

    function longint unsigned msub(longint unsigned x, longint unsigned y,
                                   longint unsigned p);
      return (x >= y) ? x - y : p - (y - x);
    endfunction

    function longint unsigned mmul(longint unsigned x, longint unsigned y,
                                   longint unsigned p);
      return (x * y) % p;
    endfunction

    // Extended Euclid; returns 0 when the denominator has no inverse.
    function bit inverse(longint unsigned d, longint unsigned p,
                         output longint unsigned res);
      longint unsigned r1, r2, c1, c2, q, r, c;
      r1 = p; r2 = d; c1 = 0; c2 = 1;
      while (r2 != 0) begin
        q = r1 / r2;
        r = r1 % r2;
        c = msub(c1, mmul(q % p, c2, p), p);
        r1 = r2; r2 = r; c1 = c2; c2 = c;
      end
      res = c1;
      return r1 == 1;
    endfunction

    function point_sum_t add_points(bit [FB-1:0] ix1, bit [FB-1:0] iy1,
                                    bit [FB-1:0] ix2, bit [FB-1:0] iy2);
      longint unsigned p, x1, y1, x2, y2, a, num, den, inv, s, x3, y3, xx;
      point_sum_t res;
      res = '{sum_y: '0, sum_x: '0, inf: 1'b1};
      p = prime;
      if (p < 2) return res;
      x1 = ix1 % p; y1 = iy1 % p; x2 = ix2 % p; y2 = iy2 % p; a = coeff % p;
      if (x1 != x2) begin
        num = msub(y2, y1, p);
        den = msub(x2, x1, p);
      end else if (y1 == y2 && y1 != 0) begin
        xx = mmul(x1, x1, p);
        num = madd(madd(madd(xx, xx, p), xx, p), a, p);
        den = madd(y1, y1, p);
      end else begin
        return res;
      end
      if (!inverse(den, p, inv)) return res;
      s = mmul(num, inv, p);
      x3 = msub(msub(mmul(s, s, p), x1, p), x2, p);
      y3 = msub(mmul(s, msub(x1, x3, p), p), y1, p);
      res.sum_x = x3[FB-1:0];
      res.sum_y = y3[FB-1:0];
      res.inf = 1'b0;
      return res;
    endfunction

    function void note_input(logic [4*FB-1:0] w);
      pending = {pending, add_points(w[FB-1:0], w[2*FB-1:FB], w[3*FB-1:2*FB],
                                     w[4*FB-1:3*FB])};
    endfunction

    function void check_result(logic [2*FB-1:0] d, logic u);
      point_sum_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d inf=%0b", $time,
                 d[FB-1:0], d[2*FB-1:FB], u);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[FB-1:0] !== e.sum_x) begin
        $display("%0t: sum_x expected %0d actual %0d", $time, e.sum_x, d[FB-1:0]);
        errors++;
      end
      if (d[2*FB-1:FB] !== e.sum_y) begin
        $display("%0t: sum_y expected %0d actual %0d", $time, e.sum_y,
                 d[2*FB-1:FB]);
        errors++;
      end
      if (u !== e.inf) begin
        $display("%0t: at_infinity expected %0b actual %0b", $time, e.inf, u);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [4*FB-1:0] in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2*FB-1:0] out_data;
  logic out_user, out_valid;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = ecpa_pkg::CfgIdxPrime;
  logic [FB-1:0] cfg_data = '0;

  point_sum_board board = new();
  int unsigned cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;

  ec_point_add_prime_field_unit #(.FIELD_BITS(FB)) DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tdata(in_data), .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .m_axis_tdata(out_data), .m_axis_tuser(out_user),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin : sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result checking at each accepted output word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data, out_user);
  end

  task automatic write_reg(logic idx, logic [FB-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ecpa_pkg::CfgIdxPrime) board.prime = val;
    else board.coeff = val;
  endtask

  task automatic send_points(logic [FB-1:0] x1, logic [FB-1:0] y1,
                             logic [FB-1:0] x2, logic [FB-1:0] y2);
    int n;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_data <= {y2, x2, y1, x1};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_input({y2, x2, y1, x1});
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  // Random operand below p most of the time, anything sometimes.
  function automatic logic [FB-1:0] coord(logic [FB-1:0] p);
    if (p > 1 && $urandom_range(0, 9) != 0) return FB'($urandom_range(0, p - 1));
    return FB'($urandom);
  endfunction

  // Mix of chord, doubling, negation and vertical-line cases.
  task automatic random_points(int count);
    logic [FB-1:0] p, x1, y1, x2, y2;
    p = board.prime;
    repeat (count) begin
      x1 = coord(p); y1 = coord(p); x2 = coord(p); y2 = coord(p);
      case ($urandom_range(0, 9))
        0, 1: begin
          x2 = x1; y2 = y1;
        end
        2: begin
          x2 = x1;
          y2 = (p > 1) ? (p - (y1 % p)) % p : y1;
        end
        3: begin
          x2 = x1; y1 = '0; y2 = '0;
        end
        default: ;
      endcase
      send_points(x1, y1, x2, y2);
    end
  endtask

  initial begin : stimulus
    logic [FB-1:0] primes[8];
    logic [FB-1:0] coeffs[8];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases at the reset field.
    send_points(16'd0, 16'd0, 16'd0, 16'd0);
    send_points(16'd1, 16'd4, 16'd1, 16'd4);
    send_points(16'd1, 16'd4, 16'd1, 16'd9);
    send_points(16'd1, 16'd4, 16'd2, 16'd4);
    send_points(16'd3, 16'd0, 16'd3, 16'd0);
    send_points(16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555);
    send_points(16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000);
    send_points(16'd14, 16'd17, 16'd1, 16'd4);
    drain();

    primes = '{16'd65521, 16'd3, 16'd0, 16'd1, 16'd65535, 16'd97, 16'd7919,
               16'd65521};
    coeffs = '{16'd65534, 16'd0, 16'd5, 16'd1, 16'hFFFF, 16'd96, 16'd1234, 16'd3};
    for (int k = 0; k < 8; k++) begin
      write_reg(ecpa_pkg::CfgIdxPrime, primes[k]);
      write_reg(ecpa_pkg::CfgIdxCoeff, coeffs[k]);
      if (k == 0) begin
        send_points(16'd0, 16'd0, 16'd65520, 16'd65520);
        send_points(16'd65520, 16'd1, 16'd65520, 16'd1);
        send_points(16'd65520, 16'd1, 16'd65520, 16'd65520);
      end
      if (k == 2) hold_off = 1'b1;
      if (k == 7) no_idle = 1'b1;
      random_points((k == 2 || k == 3) ? 50 : 250);
      drain();
    end

    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
